### rtl/core/psro_pkg.sv
// types and constants shared by the short-range-order objective block
package psro_pkg;

    localparam int MAX_SPECIES = 3;
    localparam int MAX_SHELLS  = 4;
    localparam int NPAR        = MAX_SPECIES * MAX_SPECIES * MAX_SHELLS;
    localparam int PAR_W       = 6;
    localparam int VAL_W       = 48;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // command codes of an input item
    localparam logic [1:0] CMD_WR_SPECIES = 2'd0;
    localparam logic [1:0] CMD_WR_PARAM   = 2'd1;
    localparam logic [1:0] CMD_ADD_PAIR   = 2'd2;
    localparam logic [1:0] CMD_FINISH     = 2'd3;

    // configuration register word index (paddr[2])
    localparam logic CFG_SPECIES_COUNT = 1'b0;
    localparam logic CFG_SHELL_COUNT   = 1'b1;

    localparam logic [1:0] SPECIES_COUNT_RST = 2'd2;
    localparam logic [2:0] SHELL_COUNT_RST   = 3'd1;

    typedef struct packed {
        logic [1:0]         command;
        logic [9:0]         first_atom;
        logic [9:0]         second_atom;
        logic [1:0]         species;
        logic [1:0]         shell;
        logic [PAR_W-1:0]   param_index;
        logic [31:0]        prefactor;
        logic [31:0]        weight;
        logic signed [31:0] target;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [PAR_W-1:0]        out_index;
        logic                    is_objective;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic [31:0]        prefactor;
        logic [31:0]        weight;
        logic signed [31:0] target;
    } t_param;

    typedef struct packed {
        logic [1:0] species_count;
        logic [2:0] shell_count;
    } t_cfg;

    typedef enum logic [3:0] {
        CALC_IDLE   = 4'd0,
        CALC_CLEAR  = 4'd1,
        CALC_MUL_CP = 4'd2,
        CALC_SRO    = 4'd3,
        CALC_DIFF   = 4'd4,
        CALC_MUL_LO = 4'd5,
        CALC_MUL_HI = 4'd6,
        CALC_TERM   = 4'd7,
        CALC_SUM    = 4'd8
    } t_calc_op;

endpackage

### rtl/core/psro_if.sv
// valid/ready channel interfaces for input items and result items
interface psro_in_if;
    import psro_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psro_out_if;
    import psro_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/psro_ram.sv
// simple dual-port ram, one write port and one registered read port
module psro_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/psro_cfg_regs.sv
// apb configuration registers: species count and shell count
module psro_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psro_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output psro_pkg::t_cfg                  o_cfg
);
    import psro_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.species_count <= SPECIES_COUNT_RST;
            r_cfg.shell_count   <= SHELL_COUNT_RST;
        end else if (w_wr) begin
            if (paddr[2] == CFG_SPECIES_COUNT) begin
                r_cfg.species_count <= pwdata[1:0];
            end else begin
                r_cfg.shell_count <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == CFG_SPECIES_COUNT) begin
            prdata = 32'(r_cfg.species_count);
        end else begin
            prdata = 32'(r_cfg.shell_count);
        end
    end

    assign o_cfg = r_cfg;
endmodule

### rtl/core/psro_calc_unit.sv
// shared arithmetic unit: one 32x32 multiplier plus rounding, saturation and accumulation
module psro_calc_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  psro_pkg::t_calc_op            i_op,
    input  logic [COUNT_BITS-1:0]         i_count,
    input  logic [31:0]                   i_prefactor,
    input  logic [31:0]                   i_weight,
    input  logic signed [31:0]            i_target,
    output logic [psro_pkg::VAL_W-1:0]    o_sro,
    output logic [psro_pkg::VAL_W-1:0]    o_total
);
    import psro_pkg::*;

    logic [63:0]      r_prod;
    logic [63:0]      r_lo;
    logic [VAL_W-1:0] r_sro;
    logic [48:0]      r_d;
    logic [46:0]      r_term;
    logic [46:0]      r_total;

    logic [31:0]      w_mul_a;
    logic [31:0]      w_mul_b;
    logic [63:0]      w_prod;
    logic [64:0]      w_rnd;
    logic [58:0]      w_sro_full;
    logic [VAL_W-1:0] w_sro;
    logic [49:0]      w_diff;
    logic [49:0]      w_abs;
    logic [64:0]      w_rnd_lo;
    logic [56:0]      w_t;
    logic [46:0]      w_term;
    logic [47:0]      w_sum;
    logic [46:0]      w_total;

    always_comb begin
        case (i_op)
            CALC_MUL_CP: begin
                w_mul_a = 32'(i_count);
                w_mul_b = i_prefactor;
            end
            CALC_MUL_LO: begin
                w_mul_a = r_d[31:0];
                w_mul_b = i_weight;
            end
            CALC_MUL_HI: begin
                w_mul_a = 32'(r_d[48:32]);
                w_mul_b = i_weight;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // sro = 1.0 - round(count*prefactor to q.24); only the low side can overflow
    always_comb begin
        w_rnd      = {1'b0, r_prod} + 65'd128;
        w_sro_full = 59'(1 << 24) - {2'b00, w_rnd[64:8]};
        if (w_sro_full[58:47] != {12{w_sro_full[58]}}) begin
            w_sro = VAL_MIN;
        end else begin
            w_sro = w_sro_full[47:0];
        end
    end

    always_comb begin
        w_diff = {{2{r_sro[VAL_W-1]}}, r_sro} - {{18{i_target[31]}}, i_target};
        w_abs  = w_diff[49] ? (50'd0 - w_diff) : w_diff;
    end

    // weight * |d|: high partial product in r_prod, low one in r_lo
    always_comb begin
        w_rnd_lo = {1'b0, r_lo} + 65'h800000;
        w_t      = {1'b0, r_prod[47:0], 8'h00} + 57'(w_rnd_lo[64:24]);
        if (r_prod[63:48] != 16'd0 || w_t[56:47] != 10'd0) begin
            w_term = VAL_MAX[46:0];
        end else begin
            w_term = w_t[46:0];
        end
    end

    always_comb begin
        w_sum   = {1'b0, r_total} + {1'b0, r_term};
        w_total = w_sum[47] ? VAL_MAX[46:0] : w_sum[46:0];
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            CALC_CLEAR: begin
                r_total <= '0;
            end
            CALC_MUL_CP, CALC_MUL_LO: begin
                r_prod <= w_prod;
            end
            CALC_MUL_HI: begin
                r_lo   <= r_prod;
                r_prod <= w_prod;
            end
            CALC_SRO: begin
                r_sro <= w_sro;
            end
            CALC_DIFF: begin
                r_d <= w_abs[48:0];
            end
            CALC_TERM: begin
                r_term <= w_term;
            end
            CALC_SUM: begin
                r_total <= w_total;
            end
            default: begin
            end
        endcase
    end

    assign o_sro   = r_sro;
    assign o_total = {1'b0, r_total};
endmodule

### rtl/core/pair_sro_objective_top.sv
// short-range-order objective: item sequencer, memories and result register
// Keeps a species per atom, a prefactor/weight/target per parameter and a saturating
// pair count per species pair and shell. An add-pair item reads the two species in turn,
// then bumps one count for equal species or two for differing species, none if rejected;
// the steps are set by the single read port of the species and count memories.
// A finish item walks all np = shells*species*species parameters through one shared
// 32x32 multiplier (read, multiply, sro, diff, two weight multiplies, term, sum; any
// output stall holds it) and gives one sro result per parameter in index order, then the
// objective with last set, after which all counts read as zero. The input is not ready
// while an item is being worked on. Counts start at zero after reset with no clearing pass.
// Configuration registers sit at byte address 0 (species_count) and 4 (shell_count).
module pair_sro_objective_top #(
    parameter int MAX_ATOMS  = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    psro_in_if.sink                         i_in,
    psro_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psro_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import psro_pkg::*;

    localparam int AW = $clog2(MAX_ATOMS);

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_PAIR_B   = 13'b0000000000010,
        ST_PAIR_IDX = 13'b0000000000100,
        ST_BUMP     = 13'b0000000001000,
        ST_FIN_RD   = 13'b0000000010000,
        ST_FIN_MUL0 = 13'b0000000100000,
        ST_FIN_SRO  = 13'b0000001000000,
        ST_FIN_DIFF = 13'b0000010000000,
        ST_FIN_MLO  = 13'b0000100000000,
        ST_FIN_MHI  = 13'b0001000000000,
        ST_FIN_TERM = 13'b0010000000000,
        ST_FIN_SUM  = 13'b0100000000000,
        ST_FIN_OBJ  = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    t_cfg   w_cfg;
    logic [1:0]       w_s;
    logic [2:0]       w_h;
    logic [3:0]       w_ss;
    logic [PAR_W-1:0] w_np;

    // control state
    logic             r_out_valid;
    logic [NPAR-1:0]  r_cnt_vld;

    // payload and working registers
    t_out_item        r_out;
    logic [9:0]       r_atom_b;
    logic [1:0]       r_shell;
    logic             r_a_ok;
    logic             r_b_ok;
    logic [1:0]       r_si;
    logic [PAR_W-1:0] r_idx;
    logic [PAR_W-1:0] r_idx2;
    logic             r_two;
    logic [PAR_W-1:0] r_i;

    logic             w_xfer;
    logic             w_slot_free;
    logic             w_pair_ok;
    logic [1:0]       w_sj;
    logic [PAR_W-1:0] w_base;
    logic [PAR_W-1:0] w_idx1;
    logic [PAR_W-1:0] w_idx2;
    logic [PAR_W-1:0] w_i_next;
    logic             w_load_sro;
    logic             w_load_obj;
    t_calc_op         w_op;

    logic                  w_sp_we;
    logic                  w_sp_re;
    logic [AW-1:0]         w_sp_raddr;
    logic [1:0]            w_sp_rdata;
    logic                  w_par_we;
    t_param                w_par_wdata;
    t_param                w_par;
    logic                  w_cnt_re;
    logic [PAR_W-1:0]      w_cnt_raddr;
    logic [COUNT_BITS-1:0] w_cnt_rdata;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [VAL_W-1:0]      w_sro;
    logic [VAL_W-1:0]      w_total;

    psro_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // register values outside the allowed range are clamped
    always_comb begin
        if (w_cfg.species_count == 2'd0) begin
            w_s = 2'd1;
        end else if (32'(w_cfg.species_count) > MAX_SPECIES) begin
            w_s = 2'(MAX_SPECIES);
        end else begin
            w_s = w_cfg.species_count;
        end
        if (w_cfg.shell_count == 3'd0) begin
            w_h = 3'd1;
        end else if (32'(w_cfg.shell_count) > MAX_SHELLS) begin
            w_h = 3'(MAX_SHELLS);
        end else begin
            w_h = w_cfg.shell_count;
        end
        w_ss = 4'(w_s) * 4'(w_s);
        w_np = PAR_W'(w_h) * PAR_W'(w_ss);
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_xfer      = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;

    // species memory
    assign w_sp_we    = w_xfer && (i_in.data.command == CMD_WR_SPECIES)
                        && (32'(i_in.data.first_atom) < 32'(MAX_ATOMS));
    assign w_sp_re    = (w_xfer && (i_in.data.command == CMD_ADD_PAIR))
                        || (r_state == ST_PAIR_B);
    assign w_sp_raddr = (r_state == ST_PAIR_B) ? AW'(r_atom_b) : AW'(i_in.data.first_atom);

    psro_ram #(
        .WIDTH (2),
        .DEPTH (MAX_ATOMS)
    ) u_species_mem (
        .i_clk   (i_clk),
        .i_we    (w_sp_we),
        .i_waddr (AW'(i_in.data.first_atom)),
        .i_wdata (i_in.data.species),
        .i_re    (w_sp_re),
        .i_raddr (w_sp_raddr),
        .o_rdata (w_sp_rdata)
    );

    // parameter table: prefactor, weight and target in one word
    assign w_par_we    = w_xfer && (i_in.data.command == CMD_WR_PARAM)
                         && (32'(i_in.data.param_index) < NPAR);
    assign w_par_wdata = '{prefactor: i_in.data.prefactor,
                           weight:    i_in.data.weight,
                           target:    i_in.data.target};

    psro_ram #(
        .WIDTH ($bits(t_param)),
        .DEPTH (NPAR)
    ) u_param_mem (
        .i_clk   (i_clk),
        .i_we    (w_par_we),
        .i_waddr (i_in.data.param_index),
        .i_wdata (w_par_wdata),
        .i_re    (r_state == ST_FIN_RD),
        .i_raddr (r_i),
        .o_rdata (w_par)
    );

    // pair index decode
    always_comb begin
        w_sj      = w_sp_rdata;
        w_pair_ok = r_a_ok && r_b_ok && (3'(r_shell) < w_h) && (r_si < w_s) && (w_sj < w_s);
        w_base    = PAR_W'(r_shell) * PAR_W'(w_ss);
        w_idx1    = w_base + PAR_W'(w_sj) * PAR_W'(w_s) + PAR_W'(r_si);
        w_idx2    = w_base + PAR_W'(r_si) * PAR_W'(w_s) + PAR_W'(w_sj);
    end

    // count memory; an entry without its valid bit reads as zero
    always_comb begin
        w_cnt_re    = 1'b0;
        w_cnt_raddr = r_i;
        case (r_state)
            ST_PAIR_IDX: begin
                w_cnt_re    = w_pair_ok;
                w_cnt_raddr = w_idx1;
            end
            ST_BUMP: begin
                w_cnt_re    = r_two;
                w_cnt_raddr = r_idx2;
            end
            ST_FIN_RD: begin
                w_cnt_re    = 1'b1;
                w_cnt_raddr = r_i;
            end
            default: begin
            end
        endcase
    end

    assign w_cnt     = r_cnt_vld[r_idx] ? w_cnt_rdata : '0;
    assign w_cnt_inc = (&w_cnt) ? w_cnt : w_cnt + COUNT_BITS'(1);

    psro_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NPAR)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_BUMP),
        .i_waddr (r_idx),
        .i_wdata (w_cnt_inc),
        .i_re    (w_cnt_re),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rdata)
    );

    psro_calc_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_calc (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_count     (w_cnt),
        .i_prefactor (w_par.prefactor),
        .i_weight    (w_par.weight),
        .i_target    (w_par.target),
        .o_sro       (w_sro),
        .o_total     (w_total)
    );

    assign w_i_next   = r_i + PAR_W'(1);
    assign w_load_sro = (r_state == ST_FIN_DIFF) && w_slot_free;
    assign w_load_obj = (r_state == ST_FIN_OBJ) && w_slot_free;

    // sequencer
    always_comb begin
        n_state = r_state;
        w_op    = CALC_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (w_xfer && i_in.data.command == CMD_ADD_PAIR) begin
                    n_state = ST_PAIR_B;
                end else if (w_xfer && i_in.data.command == CMD_FINISH) begin
                    w_op    = CALC_CLEAR;
                    n_state = ST_FIN_RD;
                end
            end
            ST_PAIR_B: begin
                n_state = ST_PAIR_IDX;
            end
            ST_PAIR_IDX: begin
                n_state = w_pair_ok ? ST_BUMP : ST_IDLE;
            end
            ST_BUMP: begin
                n_state = r_two ? ST_BUMP : ST_IDLE;
            end
            ST_FIN_RD: begin
                n_state = ST_FIN_MUL0;
            end
            ST_FIN_MUL0: begin
                w_op    = CALC_MUL_CP;
                n_state = ST_FIN_SRO;
            end
            ST_FIN_SRO: begin
                w_op    = CALC_SRO;
                n_state = ST_FIN_DIFF;
            end
            ST_FIN_DIFF: begin
                if (w_slot_free) begin
                    w_op    = CALC_DIFF;
                    n_state = ST_FIN_MLO;
                end
            end
            ST_FIN_MLO: begin
                w_op    = CALC_MUL_LO;
                n_state = ST_FIN_MHI;
            end
            ST_FIN_MHI: begin
                w_op    = CALC_MUL_HI;
                n_state = ST_FIN_TERM;
            end
            ST_FIN_TERM: begin
                w_op    = CALC_TERM;
                n_state = ST_FIN_SUM;
            end
            ST_FIN_SUM: begin
                w_op    = CALC_SUM;
                n_state = (w_i_next == w_np) ? ST_FIN_OBJ : ST_FIN_RD;
            end
            ST_FIN_OBJ: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load_sro || w_load_obj) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // counts of the finished run read as zero from here on
            if (w_load_obj) begin
                r_cnt_vld <= '0;
            end else if (r_state == ST_BUMP) begin
                r_cnt_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_atom_b <= i_in.data.second_atom;
            r_shell  <= i_in.data.shell;
            r_a_ok   <= 32'(i_in.data.first_atom) < 32'(MAX_ATOMS);
            r_b_ok   <= 32'(i_in.data.second_atom) < 32'(MAX_ATOMS);
            r_i      <= '0;
        end
        if (r_state == ST_PAIR_B) begin
            r_si <= w_sp_rdata;
        end
        if (r_state == ST_PAIR_IDX) begin
            r_idx  <= w_idx1;
            r_idx2 <= w_idx2;
            r_two  <= (r_si != w_sj);
        end
        if (r_state == ST_BUMP) begin
            r_idx <= r_idx2;
            r_two <= 1'b0;
        end
        if (r_state == ST_FIN_RD) begin
            r_idx <= r_i;
        end
        if (r_state == ST_FIN_SUM) begin
            r_i <= w_i_next;
        end
        if (w_load_sro) begin
            r_out.value        <= w_sro;
            r_out.out_index    <= r_i;
            r_out.is_objective <= 1'b0;
            r_out.last         <= 1'b0;
        end else if (w_load_obj) begin
            r_out.value        <= w_total;
            r_out.out_index    <= '0;
            r_out.is_objective <= 1'b1;
            r_out.last         <= 1'b1;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

### rtl/core/psro_checker.sv
// port-level assertions for the short-range-order objective block, bound to the top level
module psro_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_command,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [47:0] i_out_value,
    input logic        i_out_is_objective,
    input logic        i_out_last
);
    import psro_pkg::*;

    // a result not yet taken stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_last_is_obj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == i_out_is_objective))
        else $error("last flag and objective flag disagree");

    // a finish run keeps the input closed
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_FINISH) |=> !i_in_ready)
        else $error("input taken right after a finish transfer");

    // sro = 1 - nonnegative product never exceeds 1.0
    a_sro_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_is_objective |-> ($signed(i_out_value) <= 48'sd16777216))
        else $error("sro result above 1.0");

    a_obj_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_is_objective |-> !i_out_value[47])
        else $error("negative objective");
endmodule

bind pair_sro_objective_top psro_checker u_psro_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_command       (i_in.data.command),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_value        (o_out.data.value),
    .i_out_is_objective (o_out.data.is_objective),
    .i_out_last         (o_out.data.last)
);

### dv/tb.sv
// testbench for the short-range-order objective block: random stimulus, scoring and checking
`timescale 1ns / 1ps

module tb;
    import psro_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int STALL_CYCLES    = 400;
    localparam int HEAVY_PAIRS     = 12;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;
    localparam logic signed [63:0] SRO_TOP = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SRO_BOT = -SRO_TOP - 64'sd1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    psro_in_if  in_ch ();
    psro_out_if out_ch ();

    pair_sro_objective_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // scoring state: configuration, species per atom, tables and pair counts
    logic [1:0]         cfg_species;
    logic [2:0]         cfg_shells;
    logic [1:0]         species_mem [1024];
    logic [15:0]        pair_cnt [NPAR];
    logic [31:0]        pref_tab [NPAR];
    logic [31:0]        wt_tab [NPAR];
    logic signed [31:0] tgt_tab [NPAR];

    t_out_item   sro_expected [$];
    t_in_item    item_q [$];
    t_out_item   want;

    // stimulus bookkeeping
    bit          atom_known [1024];
    bit          param_known [NPAR];
    int unsigned known_atoms [$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          rx_stall_req = 1'b0;
    int unsigned rx_stall_left = 0;
    bit          in_xfer = 1'b0;
    bit          out_xfer = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned n_pushed = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_finish = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_errors = 0;

    int unsigned plan_species [12] = '{0, 3, 1, 3, 2, 3, 1, 3, 2, 0, 3, 2};
    int unsigned plan_shells [12]  = '{0, 7, 4, 4, 2, 1, 0, 3, 5, 6, 4, 3};
    int unsigned tx_plan [3] = '{28, 86, 0};
    int unsigned rx_plan [3] = '{86, 28, 0};

    function automatic int unsigned eff_species();
        if (cfg_species == 2'd0) return 1;
        if (32'(cfg_species) > MAX_SPECIES) return MAX_SPECIES;
        return 32'(cfg_species);
    endfunction

    function automatic int unsigned eff_shells();
        if (cfg_shells == 3'd0) return 1;
        if (32'(cfg_shells) > MAX_SHELLS) return MAX_SHELLS;
        return 32'(cfg_shells);
    endfunction

    task automatic bump_count(input int unsigned idx);
        if (idx < NPAR && pair_cnt[idx] != COUNT_TOP) begin
            pair_cnt[idx] = pair_cnt[idx] + 16'd1;
        end
    endtask

    // updates the scoring state for one accepted item and queues the sro results it causes
    task automatic score_item(input t_in_item it);
        int unsigned s, h, np, si, sj, base, k;
        logic [63:0] prod, p24, d, total;
        logic signed [63:0] sro, tgt, diff;
        logic [95:0] term;
        t_out_item r;
        s = eff_species();
        h = eff_shells();
        case (it.command)
            CMD_WR_SPECIES: begin
                species_mem[it.first_atom] = it.species;
            end
            CMD_WR_PARAM: begin
                if (it.param_index < NPAR) begin
                    pref_tab[it.param_index] = it.prefactor;
                    wt_tab[it.param_index]   = it.weight;
                    tgt_tab[it.param_index]  = it.target;
                end
            end
            CMD_ADD_PAIR: begin
                si = 32'(species_mem[it.first_atom]);
                sj = 32'(species_mem[it.second_atom]);
                if (it.shell < h && si < s && sj < s) begin
                    base = 32'(it.shell) * s * s;
                    bump_count(base + sj * s + si);
                    if (si != sj) begin
                        bump_count(base + si * s + sj);
                    end
                end
            end
            default: begin
                np = h * s * s;
                total = '0;
                for (k = 0; k < np; k++) begin
                    prod = 64'(pair_cnt[k]) * 64'(pref_tab[k]);
                    p24 = (prod + 64'd128) >> 8;
                    sro = 64'sd16777216 - $signed(p24);
                    if (sro > SRO_TOP) sro = SRO_TOP;
                    if (sro < SRO_BOT) sro = SRO_BOT;
                    tgt = 64'(tgt_tab[k]);
                    diff = sro - tgt;
                    d = (diff < 0) ? -diff : diff;
                    term = ({32'b0, d} * {64'b0, wt_tab[k]} + 96'd8388608) >> 24;
                    if (term > 96'(VAL_MAX)) term = 96'(VAL_MAX);
                    total = total + term[63:0];
                    if (total > 64'(VAL_MAX)) total = 64'(VAL_MAX);
                    r.value        = sro[VAL_W-1:0];
                    r.out_index    = k[PAR_W-1:0];
                    r.is_objective = 1'b0;
                    r.last         = 1'b0;
                    sro_expected = {sro_expected, r};
                end
                r.value        = total[VAL_W-1:0];
                r.out_index    = '0;
                r.is_objective = 1'b1;
                r.last         = 1'b1;
                sro_expected = {sro_expected, r};
                for (k = 0; k < NPAR; k++) begin
                    pair_cnt[k] = '0;
                end
            end
        endcase
    endtask

    initial begin
        for (int k = 0; k < NPAR; k++) begin
            pair_cnt[k] = '0;
        end
        cfg_species = SPECIES_COUNT_RST;
        cfg_shells  = SHELL_COUNT_RST;
    end

    // input and output monitor, scoring and watchdog
    always @(posedge i_clk) begin
        in_xfer  = 1'b0;
        out_xfer = 1'b0;
        if (i_rst_n) begin
            in_xfer  = in_ch.valid && in_ch.ready;
            out_xfer = out_ch.valid && out_ch.ready;
            if (in_xfer) begin
                score_item(in_ch.data);
                n_accepted++;
                if (in_ch.data.command == CMD_FINISH) n_finish++;
            end
            if (out_xfer) begin
                n_results++;
                if (sro_expected.size() == 0) begin
                    $error("unexpected result: value %0d index %0d", out_ch.data.value,
                           out_ch.data.out_index);
                    n_errors++;
                end else begin
                    want = sro_expected.pop_front();
                    if (out_ch.data.value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, out_ch.data.value);
                        n_errors++;
                    end
                    if (out_ch.data.out_index !== want.out_index) begin
                        $error("out_index: expected %0d, got %0d", want.out_index,
                               out_ch.data.out_index);
                        n_errors++;
                    end
                    if (out_ch.data.is_objective !== want.is_objective) begin
                        $error("is_objective: expected %0b, got %0b", want.is_objective,
                               out_ch.data.is_objective);
                        n_errors++;
                    end
                    if (out_ch.data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, out_ch.data.last);
                        n_errors++;
                    end
                end
            end
            if (in_xfer || out_xfer) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("tb: watchdog expired with %0d results outstanding",
                         sro_expected.size());
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // input driver: holds an item until its transfer, then maybe idles
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_xfer) begin
                if (item_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    in_ch.data  <= item_q.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random idling and an occasional long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rx_stall_req) begin
                rx_stall_req  = 1'b0;
                rx_stall_left = STALL_CYCLES;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 255);
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'h0100_0000 + $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    // unused fields carry random noise
    function automatic t_in_item blank_item(input logic [1:0] cmd);
        t_in_item it;
        it = {$urandom(), $urandom(), $urandom(), $urandom()};
        it.command = cmd;
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        while (item_q.size() >= 16) @(negedge i_clk);
        if (it.command == CMD_WR_SPECIES && !atom_known[it.first_atom]) begin
            atom_known[it.first_atom] = 1'b1;
            known_atoms = {known_atoms, 32'(it.first_atom)};
        end
        if (it.command == CMD_WR_PARAM && it.param_index < NPAR) begin
            param_known[it.param_index] = 1'b1;
        end
        item_q = {item_q, it};
        n_pushed++;
    endtask

    task automatic push_species(input logic [9:0] atom, input logic [1:0] sp);
        t_in_item it;
        it = blank_item(CMD_WR_SPECIES);
        it.first_atom = atom;
        it.species    = sp;
        push_item(it);
    endtask

    task automatic push_param(input logic [5:0] idx, input logic [31:0] pf,
                              input logic [31:0] wt, input logic [31:0] tg);
        t_in_item it;
        it = blank_item(CMD_WR_PARAM);
        it.param_index = idx;
        it.prefactor   = pf;
        it.weight      = wt;
        it.target      = tg;
        push_item(it);
    endtask

    task automatic push_pair(input logic [9:0] a, input logic [9:0] b, input logic [1:0] sh);
        t_in_item it;
        it = blank_item(CMD_ADD_PAIR);
        it.first_atom  = a;
        it.second_atom = b;
        it.shell       = sh;
        push_item(it);
    endtask

    task automatic push_finish();
        push_item(blank_item(CMD_FINISH));
    endtask

    function automatic int unsigned any_known_atom();
        return known_atoms[$urandom_range(0, known_atoms.size() - 1)];
    endfunction

    // species writes, missing parameters, a run of pairs, then a finish
    task automatic run_episode(input int unsigned n_pairs);
        int unsigned s, h, np, k, a;
        s = eff_species();
        h = eff_shells();
        np = h * s * s;
        repeat ($urandom_range(1, 4)) begin
            a = ($urandom_range(0, 2) == 0) ? any_known_atom() : $urandom_range(0, 1023);
            push_species(10'(a), 2'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 3)
                                                                 : $urandom_range(0, s - 1)));
        end
        for (k = 0; k < np; k++) begin
            if (!param_known[k]) push_param(6'(k), pick_word(), pick_word(), pick_word());
        end
        if ($urandom_range(0, 2) == 0) begin
            push_param(6'($urandom_range(0, np - 1)), pick_word(), pick_word(), pick_word());
        end
        if ($urandom_range(0, 7) == 0) begin
            push_param(6'($urandom_range(NPAR, 63)), pick_word(), pick_word(), pick_word());
        end
        repeat (n_pairs) begin
            push_pair(10'(any_known_atom()), 10'(any_known_atom()),
                      2'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, h - 1)));
            if ($urandom_range(0, 11) == 0) begin
                push_species(10'(any_known_atom()), 2'($urandom_range(0, s - 1)));
            end
        end
        push_finish();
    endtask

    // wait until every item is taken and every result has come, then let the block settle
    task automatic wait_idle();
        while (n_accepted != n_pushed || sro_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == CFG_SPECIES_COUNT) cfg_species = v[1:0];
        else cfg_shells = v[2:0];
        n_cfg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int unsigned ph, k, idx;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        tx_idle_pct  = tx_plan[0];
        rx_idle_pct  = rx_plan[0];
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part under the reset configuration: two species, one shell
        push_species(10'd0, 2'd0);
        push_species(10'd1023, 2'd1);
        push_species(10'd512, 2'd1);
        push_species(10'd682, 2'd2);
        push_species(10'd341, 2'd0);
        push_species(10'd77, 2'd3);
        push_param(6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        push_param(6'd1, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        push_param(6'd2, $urandom(), $urandom(), $urandom());
        push_param(6'd3, 32'h0100_0000, 32'h0100_0000, 32'h0000_0000);
        push_param(6'd63, $urandom(), $urandom(), $urandom());
        push_pair(10'd0, 10'd341, 2'd0);
        push_pair(10'd0, 10'd1023, 2'd0);
        push_pair(10'd1023, 10'd512, 2'd0);
        // species outside the configured range, shells outside the configured range
        push_pair(10'd682, 10'd0, 2'd0);
        push_pair(10'd77, 10'd0, 2'd0);
        push_pair(10'd0, 10'd1023, 2'd1);
        push_pair(10'd341, 10'd512, 2'd3);
        push_finish();
        // counts were cleared by the previous finish
        push_finish();

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = tx_plan[ph];
            rx_idle_pct = rx_plan[ph];
            for (k = 0; k < 4; k++) begin
                idx = ph * 4 + k;
                wait_idle();
                cfg_write(CFG_SPECIES_COUNT, plan_species[idx]);
                cfg_write(CFG_SHELL_COUNT, plan_shells[idx]);
                if (ph == 2 && k == 0) begin
                    @(posedge i_clk);
                    rx_stall_req = 1'b1;
                end
                repeat (2) run_episode($urandom_range(3, 14));
            end
        end

        // build up two mirrored counts under the largest coefficients
        wait_idle();
        cfg_write(CFG_SPECIES_COUNT, 32'd2);
        cfg_write(CFG_SHELL_COUNT, 32'd1);
        push_species(10'd100, 2'd0);
        push_species(10'd923, 2'd1);
        for (k = 0; k < 4; k++) begin
            push_param(6'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        end
        repeat (HEAVY_PAIRS) push_pair(10'd100, 10'd923, 2'd0);
        push_finish();
        push_finish();
        wait_idle();

        $display("tb: %0d items taken, %0d results checked over %0d finish runs",
                 n_accepted, n_results, n_finish);
        $display("tb: %0d register writes, three idling phases, extreme coefficients",
                 n_cfg_writes);
        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
